// File: hw/rtl/slpr_pkg.sv
package slpr_pkg;

    // preamble bytes
    localparam logic [7:0] PRE0 = 8'hBE;
    localparam logic [7:0] PRE1 = 8'hEF;
    localparam logic [7:0] PRE2 = 8'hED;

    // crc-16-ccitt polynomial, msb first
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // register indexes of the configuration port
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PROTOCOL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PORT     = 1'b1;

    // header byte positions after the preamble
    localparam logic [2:0] HDR_DEST    = 3'd0;
    localparam logic [2:0] HDR_SRC     = 3'd1;
    localparam logic [2:0] HDR_TYPE    = 3'd2;
    localparam logic [2:0] HDR_SIZE_HI = 3'd3;
    localparam logic [2:0] HDR_SIZE_LO = 3'd4;
    localparam logic [2:0] HDR_XID     = 3'd5;

    typedef enum logic [2:0] {
        PH_HUNT0  = 3'd0,
        PH_HUNT1  = 3'd1,
        PH_HUNT2  = 3'd2,
        PH_HEADER = 3'd3,
        PH_BODY   = 3'd4,
        PH_CRC    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_GOOD   = 2'd2,
        KIND_BAD    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [7:0]  source_port;
        logic [7:0]  packet_type;
        logic [7:0]  transaction_id;
        logic [15:0] body_length;
        logic        is_last;
    } t_result;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/slpr_rx_if.sv
interface slpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/slpr_res_if.sv
interface slpr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  source_port;
    logic [7:0]  packet_type;
    logic [7:0]  transaction_id;
    logic [15:0] body_length;
    logic        is_last;

    modport source (
        output valid, output kind, output data_byte, output source_port,
        output packet_type, output transaction_id, output body_length,
        output is_last, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input source_port,
        input packet_type, input transaction_id, input body_length,
        input is_last, output ready
    );
endinterface

// File: hw/rtl/slpr_deframer.sv
module slpr_deframer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_local_protocol,
    input  logic [7:0]        i_local_port,
    output logic              o_res_valid,
    output slpr_pkg::t_result o_res
);
    import slpr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_dest, n_dest;
    logic [7:0]  r_src, n_src;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_size, n_size;
    logic [7:0]  r_xid, n_xid;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_crc, n_crc;
    logic        r_drop, n_drop;

    logic [15:0] crc_next;
    logic [15:0] count_inc;
    logic        drop_now;

    assign crc_next  = crc_update(r_crc, i_byte);
    assign count_inc = r_count + 16'd1;
    assign drop_now  = !((r_type == i_local_protocol) && (r_dest == i_local_port));

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_dest  = r_dest;
        n_src   = r_src;
        n_type  = r_type;
        n_size  = r_size;
        n_xid   = r_xid;
        n_sum   = r_sum;
        n_crc   = r_crc;
        n_drop  = r_drop;

        o_res_valid          = 1'b0;
        o_res.kind           = KIND_HEADER;
        o_res.data_byte      = 8'h00;
        o_res.source_port    = r_src;
        o_res.packet_type    = r_type;
        o_res.transaction_id = r_xid;
        o_res.body_length    = r_size;
        o_res.is_last        = 1'b0;

        unique case (r_phase)
            PH_HUNT1, PH_HUNT2: begin
                if (i_byte != ((r_phase == PH_HUNT1) ? PRE1 : PRE2)) begin
                    n_phase = PH_HUNT0;
                    n_count = 16'd0;
                end else begin
                    n_sum = r_sum + i_byte;
                    n_crc = crc_next;
                    if (r_phase == PH_HUNT2) begin
                        n_phase = PH_HEADER;
                        n_count = 16'd0;
                    end else begin
                        n_phase = PH_HUNT2;
                    end
                end
            end
            PH_HEADER: begin
                n_crc   = crc_next;
                n_count = count_inc;
                unique case (r_count[2:0])
                    HDR_DEST:    n_dest = i_byte;
                    HDR_SRC:     n_src  = i_byte;
                    HDR_TYPE:    n_type = i_byte;
                    HDR_SIZE_HI: n_size = {i_byte, r_size[7:0]};
                    HDR_SIZE_LO: n_size = {r_size[15:8], i_byte};
                    HDR_XID:     n_xid  = i_byte;
                    default: begin
                        // checksum byte: compare, then filter on type and dest
                        n_count = 16'd0;
                        if (i_byte != r_sum) begin
                            n_phase = PH_HUNT0;
                        end else begin
                            n_drop      = drop_now;
                            n_phase     = (r_size == 16'd0) ? PH_CRC : PH_BODY;
                            o_res_valid = !drop_now;
                        end
                    end
                endcase
                if (r_count < 16'd6) begin
                    n_sum = r_sum + i_byte;
                end
            end
            PH_BODY: begin
                n_crc = crc_next;
                if (count_inc >= r_size) begin
                    n_phase = PH_CRC;
                    n_count = 16'd0;
                end else begin
                    n_count = count_inc;
                end
                o_res_valid     = !r_drop;
                o_res.kind      = KIND_BODY;
                o_res.data_byte = i_byte;
            end
            PH_CRC: begin
                n_crc = crc_next;
                if (r_count == 16'd0) begin
                    n_count = 16'd1;
                end else begin
                    n_phase       = PH_HUNT0;
                    n_count       = 16'd0;
                    o_res_valid   = !r_drop;
                    o_res.kind    = (crc_next == 16'd0) ? KIND_GOOD : KIND_BAD;
                    o_res.is_last = 1'b1;
                end
            end
            default: begin
                // first preamble byte, unused phase codes land here too
                n_phase = PH_HUNT0;
                n_count = 16'd0;
                if (i_byte == PRE0) begin
                    n_sum   = i_byte;
                    n_crc   = crc_update(16'h0000, i_byte);
                    n_phase = PH_HUNT1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT0;
            r_count <= 16'd0;
            r_dest  <= 8'h00;
            r_src   <= 8'h00;
            r_type  <= 8'h00;
            r_size  <= 16'd0;
            r_xid   <= 8'h00;
            r_sum   <= 8'h00;
            r_crc   <= 16'h0000;
            r_drop  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_dest  <= n_dest;
            r_src   <= n_src;
            r_type  <= n_type;
            r_size  <= n_size;
            r_xid   <= n_xid;
            r_sum   <= n_sum;
            r_crc   <= n_crc;
            r_drop  <= n_drop;
        end
    end

endmodule

// File: hw/rtl/slpr_out_reg.sv
module slpr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  slpr_pkg::t_result i_res,
    output logic              o_free,
    slpr_res_if.source        o_res
);
    import slpr_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.kind           = r_data.kind;
    assign o_res.data_byte      = r_data.data_byte;
    assign o_res.source_port    = r_data.source_port;
    assign o_res.packet_type    = r_data.packet_type;
    assign o_res.transaction_id = r_data.transaction_id;
    assign o_res.body_length    = r_data.body_length;
    assign o_res.is_last        = r_data.is_last;

endmodule

// File: hw/rtl/serial_link_packet_receiver_core.sv
// serial link packet receiver: byte-serial deframer
// i_rx carries one received byte per item (valid/ready); o_res carries one
// result item per accepted header, per body byte of an accepted packet, and
// one end item per accepted packet (kind good or bad crc, is_last set)
// the deframer hunts for the preamble BE EF ED, gathers the header, checks the
// 8-bit header sum, filters on type/dest against the local registers and runs
// a crc-16-ccitt over every byte of the frame
// path: a byte taken from i_rx goes into the input register, and the deframer
// step then carries its result item into the output register that drives o_res
// throughput: one byte per cycle while o_res is not held off; the header/crc
// step is one short pass of logic between the input and result registers
// configuration: i_cfg_we writes local_protocol (index 0) or local_port
// (index 1); write only while the block is idle
// reset (synchronous, active low) returns to the preamble hunt, clears all
// header state and both registers, and empties the input and output registers
// stall: while o_res is held off with an item waiting, the input register keeps
// at most one byte and i_rx.ready is low whenever it holds one
module serial_link_packet_receiver_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    slpr_rx_if.sink                             i_rx,
    slpr_res_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [slpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);
    import slpr_pkg::*;

    // configuration registers
    logic [7:0] r_local_protocol;
    logic [7:0] r_local_port;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic       out_free;
    logic       advance;
    logic       step_valid;
    t_result    step_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_protocol <= 8'h00;
            r_local_port     <= 8'h00;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOCAL_PROTOCOL: r_local_protocol <= i_cfg_data;
                CFG_LOCAL_PORT:     r_local_port     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the held byte moves on when the output register can take a result
    assign advance    = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    slpr_deframer u_deframer (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (advance),
        .i_byte           (r_in_byte),
        .i_local_protocol (r_local_protocol),
        .i_local_port     (r_local_port),
        .o_res_valid      (step_valid),
        .o_res            (step_res)
    );

    slpr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && step_valid),
        .i_res   (step_res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule
